// ----- sv/ahpv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ahpv_pkg;

   // Parse position within the authority text.
   typedef enum logic [2:0] {
      MODE_START         = 3'd0,
      MODE_PLAIN         = 3'd1,
      MODE_LITERAL       = 3'd2,
      MODE_AFTER_BRACKET = 3'd3,
      MODE_PORT_PLAIN    = 3'd4,
      MODE_PORT_BRACKET  = 3'd5
   } mode_type;

   localparam logic [16:0] PORT_LIMIT      = 17'd65535;
   localparam logic [7:0]  HOST_SATURATE   = 8'd255;
   localparam logic [3:0]  FULL_GROUPS     = 4'd8;
   localparam logic [4:0]  GAP_GROUPS_MAX  = 5'd7;
   localparam logic [3:0]  GROUP_SATURATE  = 4'd15;
   localparam logic [9:0]  OCTET_MAX       = 10'd255;

   localparam logic [7:0]  CHAR_COLON      = 8'h3A;
   localparam logic [7:0]  CHAR_DOT        = 8'h2E;
   localparam logic [7:0]  CHAR_LBRACKET   = 8'h5B;
   localparam logic [7:0]  CHAR_RBRACKET   = 8'h5D;

   localparam int RSP_DATA_WIDTH = 32;

   // Adds one or two groups to a four-bit group count, holding at the top.
   function automatic logic [3:0] add_groups_sat(input logic [3:0] count,
                                                 input logic [1:0] amount);
      logic [4:0] sum;
      sum = {1'b0, count} + {3'b000, amount};
      if (sum > {1'b0, GROUP_SATURATE}) begin
         return GROUP_SATURATE;
      end
      return sum[3:0];
   endfunction

endpackage

`default_nettype wire

// ----- sv/authority_host_port_validator.sv -----
// Flow: an accepted character transfer is registered in the input stage and
//   parsed from there; the result for the last character is then loaded into
//   the result register, which drives rsp.
// Throughput: one character per cycle while the result register can take each result.
// Reset: synchronous, active high; clears the input and result stages and returns
//   the parser to the start of an authority.
`timescale 1ns / 1ps
`default_nettype none

module authority_host_port_validator
   import ahpv_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output      logic                      req_tready,
   input  wire logic [7:0]                req_tdata,  // [7:0] char_code
   input  wire logic                      req_tuser,  // [0] char_present
   input  wire logic                      req_tlast,  // last
   output      logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [0] valid_res, [1] host_is_ipv6, [9:2] host_length, [10] port_present,
   // [26:11] port_value, [31:27] zero
   output      logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   // The input stage holds one character. It drains whenever it holds a
   // non-final character, or when the result register is free to take the
   // result that a final character produces. The input side is therefore
   // ready again in the same cycle, so a transfer can happen every cycle.

   logic                      s1_valid_ff;
   logic [7:0]                s1_char_ff;
   logic                      s1_present_ff;
   logic                      s1_last_ff;

   logic                      out_free;
   logic                      consume;

   // Parser state.
   mode_type                  mode_ff, mode_in;
   logic                      error_ff, error_in;
   logic [7:0]                host_count_ff, host_count_in;
   logic [2:0]                group_digits_ff, group_digits_in;
   logic [3:0]                groups_before_ff, groups_before_in;
   logic [3:0]                groups_after_ff, groups_after_in;
   logic                      gap_seen_ff, gap_seen_in;
   logic                      prev_colon_ff, prev_colon_in;
   logic [9:0]                group_dec_ff, group_dec_in;
   logic                      group_all_dec_ff, group_all_dec_in;
   logic                      dotted_ff, dotted_in;
   logic [2:0]                octet_count_ff, octet_count_in;
   logic [16:0]               port_acc_ff, port_acc_in;
   logic [2:0]                port_digits_ff, port_digits_in;

   logic                      rsp_valid_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign consume    = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_tready = !s1_valid_ff || consume;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         s1_char_ff    <= req_tdata;
         s1_present_ff <= req_tuser;
         s1_last_ff    <= req_tlast;
      end
   end

   // Next-state logic mirrors the character rules step by step; the working
   // values are updated in order so that later checks see earlier updates.
   always_comb begin
      logic       is_dec;
      logic       is_hex;
      logic       octet_ok;
      logic [3:0] digit;
      logic       result_ok;
      logic       bracket;
      logic       port_shown;

      mode_in          = mode_ff;
      error_in         = error_ff;
      host_count_in    = host_count_ff;
      group_digits_in  = group_digits_ff;
      groups_before_in = groups_before_ff;
      groups_after_in  = groups_after_ff;
      gap_seen_in      = gap_seen_ff;
      prev_colon_in    = prev_colon_ff;
      group_dec_in     = group_dec_ff;
      group_all_dec_in = group_all_dec_ff;
      dotted_in        = dotted_ff;
      octet_count_in   = octet_count_ff;
      port_acc_in      = port_acc_ff;
      port_digits_in   = port_digits_ff;
      rsp_data_in      = '0;
      result_ok        = 1'b0;
      bracket          = 1'b0;
      port_shown       = 1'b0;

      is_dec   = s1_char_ff inside {[8'h30:8'h39]};
      is_hex   = s1_char_ff inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
      digit    = s1_char_ff[3:0];
      octet_ok = 1'b0;

      if (s1_present_ff) begin
         case (mode_ff)
            MODE_START: begin
               if (s1_char_ff == CHAR_LBRACKET) begin
                  mode_in       = MODE_LITERAL;
                  host_count_in = host_count_ff + 8'd1;
               end else if (s1_char_ff == CHAR_COLON) begin
                  mode_in = MODE_PORT_PLAIN;
               end else begin
                  mode_in       = MODE_PLAIN;
                  host_count_in = host_count_ff + 8'd1;
               end
            end
            MODE_PLAIN: begin
               if (s1_char_ff == CHAR_COLON) begin
                  mode_in = MODE_PORT_PLAIN;
               end else if (host_count_ff < HOST_SATURATE) begin
                  host_count_in = host_count_ff + 8'd1;
               end
            end
            MODE_LITERAL: begin
               if (host_count_ff < HOST_SATURATE) begin
                  host_count_in = host_count_ff + 8'd1;
               end
               octet_ok = (group_digits_ff >= 3'd1) && (group_digits_ff <= 3'd3) &&
                          (group_dec_ff <= OCTET_MAX);
               if (s1_char_ff == CHAR_RBRACKET) begin
                  // Close the literal: account for the final group, then
                  // check the total group count.
                  if (prev_colon_ff) begin
                     if (!(gap_seen_ff && groups_after_ff == 4'd0)) begin
                        error_in = 1'b1;
                     end
                  end else if (dotted_ff) begin
                     if (!octet_ok || octet_count_ff != 3'd3) begin
                        error_in = 1'b1;
                     end else if (gap_seen_ff) begin
                        groups_after_in = add_groups_sat(groups_after_ff, 2'd2);
                     end else begin
                        groups_before_in = add_groups_sat(groups_before_ff, 2'd2);
                     end
                  end else if (group_digits_ff != 3'd0) begin
                     if (gap_seen_ff) begin
                        groups_after_in = add_groups_sat(groups_after_ff, 2'd1);
                     end else begin
                        groups_before_in = add_groups_sat(groups_before_ff, 2'd1);
                     end
                  end
                  if (gap_seen_ff) begin
                     if ({1'b0, groups_before_in} + {1'b0, groups_after_in} >
                         GAP_GROUPS_MAX) begin
                        error_in = 1'b1;
                     end
                  end else if (groups_before_in != FULL_GROUPS) begin
                     error_in = 1'b1;
                  end
                  mode_in = MODE_AFTER_BRACKET;
               end else if (s1_char_ff == CHAR_COLON) begin
                  if (dotted_ff) begin
                     error_in = 1'b1;
                  end else if (prev_colon_ff) begin
                     if (gap_seen_ff) begin
                        error_in = 1'b1;
                     end else begin
                        gap_seen_in = 1'b1;
                     end
                  end else if (group_digits_ff != 3'd0) begin
                     if (gap_seen_ff) begin
                        groups_after_in = add_groups_sat(groups_after_ff, 2'd1);
                     end else begin
                        groups_before_in = add_groups_sat(groups_before_ff, 2'd1);
                     end
                  end
                  group_digits_in  = 3'd0;
                  group_dec_in     = 10'd0;
                  group_all_dec_in = 1'b1;
                  prev_colon_in    = 1'b1;
               end else if (s1_char_ff == CHAR_DOT) begin
                  if (group_digits_ff == 3'd0 || prev_colon_ff) begin
                     error_in = 1'b1;
                  end else if (!dotted_ff) begin
                     if (!group_all_dec_ff || !octet_ok) begin
                        error_in = 1'b1;
                     end
                     dotted_in      = 1'b1;
                     octet_count_in = 3'd1;
                  end else if (!octet_ok || octet_count_ff >= 3'd3) begin
                     error_in = 1'b1;
                  end else begin
                     octet_count_in = octet_count_ff + 3'd1;
                  end
                  group_digits_in  = 3'd0;
                  group_dec_in     = 10'd0;
                  group_all_dec_in = 1'b1;
               end else if (is_hex) begin
                  // A single leading colon is not allowed.
                  if (prev_colon_ff && !gap_seen_ff && groups_before_ff == 4'd0) begin
                     error_in = 1'b1;
                  end
                  prev_colon_in = 1'b0;
                  if (dotted_ff && !is_dec) begin
                     error_in = 1'b1;
                  end
                  if (!is_dec) begin
                     group_all_dec_in = 1'b0;
                  end
                  if (group_digits_ff < 3'd5) begin
                     group_digits_in = group_digits_ff + 3'd1;
                  end
                  if (group_digits_in > 3'd4) begin
                     error_in = 1'b1;
                  end
                  if (is_dec && group_all_dec_in && group_digits_in <= 3'd3) begin
                     group_dec_in = (group_dec_ff << 3) + (group_dec_ff << 1) +
                                    {6'd0, digit};
                  end
               end else begin
                  error_in = 1'b1;
               end
            end
            MODE_AFTER_BRACKET: begin
               if (s1_char_ff == CHAR_COLON) begin
                  mode_in = MODE_PORT_BRACKET;
               end else begin
                  error_in = 1'b1;
               end
            end
            default: begin
               // Port digits, in either port mode.
               if (!is_dec) begin
                  error_in = 1'b1;
               end else begin
                  if (port_digits_ff < 3'd6) begin
                     port_digits_in = port_digits_ff + 3'd1;
                  end
                  if (port_digits_in > 3'd5) begin
                     error_in = 1'b1;
                  end else begin
                     port_acc_in = (port_acc_ff << 3) + (port_acc_ff << 1) +
                                   {13'd0, digit};
                  end
               end
            end
         endcase
      end

      if (s1_last_ff) begin
         if (mode_in == MODE_LITERAL) begin
            error_in = 1'b1;
         end
         if (port_digits_in != 3'd0 && port_acc_in > PORT_LIMIT) begin
            error_in = 1'b1;
         end
         result_ok  = !error_in;
         bracket    = (mode_in == MODE_LITERAL) || (mode_in == MODE_AFTER_BRACKET) ||
                      (mode_in == MODE_PORT_BRACKET);
         port_shown = result_ok && (port_digits_in != 3'd0);
         rsp_data_in[0]     = result_ok;
         rsp_data_in[1]     = bracket;
         rsp_data_in[9:2]   = host_count_in;
         rsp_data_in[10]    = port_shown;
         rsp_data_in[26:11] = port_shown ? port_acc_in[15:0] : 16'd0;

         // The authority is complete: start over for the next one.
         mode_in          = MODE_START;
         error_in         = 1'b0;
         host_count_in    = 8'd0;
         group_digits_in  = 3'd0;
         groups_before_in = 4'd0;
         groups_after_in  = 4'd0;
         gap_seen_in      = 1'b0;
         prev_colon_in    = 1'b0;
         group_dec_in     = 10'd0;
         group_all_dec_in = 1'b1;
         dotted_in        = 1'b0;
         octet_count_in   = 3'd0;
         port_acc_in      = 17'd0;
         port_digits_in   = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= MODE_START;
         error_ff         <= 1'b0;
         host_count_ff    <= 8'd0;
         group_digits_ff  <= 3'd0;
         groups_before_ff <= 4'd0;
         groups_after_ff  <= 4'd0;
         gap_seen_ff      <= 1'b0;
         prev_colon_ff    <= 1'b0;
         group_dec_ff     <= 10'd0;
         group_all_dec_ff <= 1'b1;
         dotted_ff        <= 1'b0;
         octet_count_ff   <= 3'd0;
         port_acc_ff      <= 17'd0;
         port_digits_ff   <= 3'd0;
      end else if (consume) begin
         mode_ff          <= mode_in;
         error_ff         <= error_in;
         host_count_ff    <= host_count_in;
         group_digits_ff  <= group_digits_in;
         groups_before_ff <= groups_before_in;
         groups_after_ff  <= groups_after_in;
         gap_seen_ff      <= gap_seen_in;
         prev_colon_ff    <= prev_colon_in;
         group_dec_ff     <= group_dec_in;
         group_all_dec_ff <= group_all_dec_in;
         dotted_ff        <= dotted_in;
         octet_count_ff   <= octet_count_in;
         port_acc_ff      <= port_acc_in;
         port_digits_ff   <= port_digits_in;
      end
   end

   // Result register: loaded by a final character, cleared when taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (consume && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (consume && s1_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire
